@@ src/assert_macros.svh @@
// Assertion helpers, sampled on the rising clock edge, off while reset is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property holds in the same cycle.
`define DFA_ASSERT(name, cond) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error("dfa assertion failed");

// Consequent holds in the cycle after the antecedent.
`define DFA_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("dfa assertion failed");

`endif

@@ src/dfa_pkg.sv @@
package dfa_pkg;

    localparam int FRAC_BITS = 16;
    localparam int VOL_W     = 31;
    localparam int DIST_W    = 31;
    localparam int PREF_W    = 31;
    localparam int VAL_W     = 32;
    localparam int ACC_W     = 48;
    localparam int PROD_W    = 2 * VAL_W;
    localparam int SH_W      = PROD_W - FRAC_BITS;
    localparam int WIDE_W    = SH_W + 3;
    localparam int DVD_W     = VOL_W + FRAC_BITS;
    localparam int DIV_STEPS = DVD_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);
    localparam int IN_DATA_W = 256;
    localparam int OUT_DATA_W = 96;
    localparam int Q_DEPTH   = 2;

    localparam logic [PREF_W-1:0] PREF_RESET = PREF_W'(1) << FRAC_BITS;

    typedef struct packed {
        logic [VOL_W-1:0]        source_volume;
        logic [DIST_W-1:0]       dist_cube;
        logic signed [VAL_W-1:0] moment_x;
        logic signed [VAL_W-1:0] moment_y;
        logic signed [VAL_W-1:0] moment_z;
        logic signed [VAL_W-1:0] dir_x;
        logic signed [VAL_W-1:0] dir_y;
        logic signed [VAL_W-1:0] dir_z;
        logic                    last_term;
    } t_item;

    typedef struct packed {
        logic  valid;
        t_item item;
    } t_queue_out;

    typedef struct packed {
        logic                    clip;
        logic signed [VAL_W-1:0] val;
    } t_sat;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DIV,
        S_DOT_MUL,
        S_DOT_ACC,
        S_COEF_MUL,
        S_COEF,
        S_AX_MUL1,
        S_AX_INNER,
        S_AX_MUL2,
        S_AX_ACC,
        S_DONE
    } t_state;

endpackage

@@ src/dfa_front.sv @@
module dfa_front (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [dfa_pkg::IN_DATA_W-1:0]    s_axis_tdata,
    input  logic                             s_axis_tlast,
    input  logic                             i_pop,
    output dfa_pkg::t_queue_out              o_head
);

    localparam int PTR_W = $clog2(dfa_pkg::Q_DEPTH);

    dfa_pkg::t_item         r_mem [dfa_pkg::Q_DEPTH];
    logic [PTR_W-1:0]       r_wr;
    logic [PTR_W-1:0]       r_rd;
    logic [PTR_W:0]         r_cnt;
    dfa_pkg::t_item         w_in;
    logic                   w_push;
    logic                   w_pop;

    // Unpack beat: volume, cube, moment xyz, direction xyz from bit 0 up.
    always_comb begin
        w_in.source_volume = s_axis_tdata[30:0];
        w_in.dist_cube     = s_axis_tdata[61:31];
        w_in.moment_x      = s_axis_tdata[93:62];
        w_in.moment_y      = s_axis_tdata[125:94];
        w_in.moment_z      = s_axis_tdata[157:126];
        w_in.dir_x         = s_axis_tdata[189:158];
        w_in.dir_y         = s_axis_tdata[221:190];
        w_in.dir_z         = s_axis_tdata[253:222];
        w_in.last_term     = s_axis_tlast;
    end

    assign s_axis_tready = (r_cnt != (PTR_W+1)'(dfa_pkg::Q_DEPTH));
    assign w_push        = s_axis_tvalid && s_axis_tready;
    assign w_pop         = i_pop && (r_cnt != '0);
    assign o_head.valid  = (r_cnt != '0);
    assign o_head.item   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= w_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wr <= r_wr + PTR_W'(1);
            end
            if (w_pop) begin
                r_rd <= r_rd + PTR_W'(1);
            end
            case ({w_push, w_pop})
                2'b10:   r_cnt <= r_cnt + (PTR_W+1)'(1);
                2'b01:   r_cnt <= r_cnt - (PTR_W+1)'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

@@ src/dfa_div.sv @@
module dfa_div (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [dfa_pkg::DVD_W-1:0]      i_dividend,
    input  logic [dfa_pkg::DIST_W-1:0]     i_divisor,
    output logic                           o_busy,
    output logic [dfa_pkg::DVD_W-1:0]      o_quot
);

    logic                           r_busy;
    logic [dfa_pkg::DIV_CNT_W-1:0]  r_cnt;
    logic [dfa_pkg::DIST_W:0]       r_rem;
    logic [dfa_pkg::DVD_W-1:0]      r_dvd;
    logic [dfa_pkg::DVD_W-1:0]      r_quo;
    logic [dfa_pkg::DIST_W-1:0]     r_dsr;
    logic [dfa_pkg::DIST_W:0]       w_trial;
    logic                           w_ge;

    // Restoring division, one quotient bit a cycle. A zero divisor yields all ones.
    assign w_trial = {r_rem[dfa_pkg::DIST_W-1:0], r_dvd[dfa_pkg::DVD_W-1]};
    assign w_ge    = (w_trial >= {1'b0, r_dsr});
    assign o_busy  = r_busy;
    assign o_quot  = r_quo;

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_dvd <= i_dividend;
            r_dsr <= i_divisor;
            r_quo <= '0;
        end else if (r_busy) begin
            r_rem <= w_ge ? (w_trial - {1'b0, r_dsr}) : w_trial;
            r_dvd <= {r_dvd[dfa_pkg::DVD_W-2:0], 1'b0};
            r_quo <= {r_quo[dfa_pkg::DVD_W-2:0], w_ge};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + dfa_pkg::DIV_CNT_W'(1);
            if (r_cnt == dfa_pkg::DIV_CNT_W'(dfa_pkg::DIV_STEPS - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

endmodule

@@ src/dfa_back.sv @@
`include "assert_macros.svh"

module dfa_back (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic [dfa_pkg::PREF_W-1:0]         i_prefactor,
    input  dfa_pkg::t_queue_out                i_head,
    output logic                               o_pop,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic [dfa_pkg::OUT_DATA_W-1:0]     o_out_data,
    output logic                               o_out_sat
);

    localparam logic signed [dfa_pkg::WIDE_W-1:0] MAX32 =
        dfa_pkg::WIDE_W'(64'sd2147483647);
    localparam logic signed [dfa_pkg::WIDE_W-1:0] MIN32 =
        dfa_pkg::WIDE_W'(-64'sd2147483648);
    localparam logic signed [dfa_pkg::ACC_W:0] MAX48 =
        (dfa_pkg::ACC_W+1)'(64'sd140737488355327);
    localparam logic signed [dfa_pkg::ACC_W:0] MIN48 =
        (dfa_pkg::ACC_W+1)'(-64'sd140737488355328);

    function automatic dfa_pkg::t_sat sat32(input logic signed [dfa_pkg::WIDE_W-1:0] x);
        dfa_pkg::t_sat r;
        if (x > MAX32) begin
            r.clip = 1'b1;
            r.val  = dfa_pkg::VAL_W'(MAX32);
        end else if (x < MIN32) begin
            r.clip = 1'b1;
            r.val  = dfa_pkg::VAL_W'(MIN32);
        end else begin
            r.clip = 1'b0;
            r.val  = dfa_pkg::VAL_W'(x);
        end
        return r;
    endfunction

    dfa_pkg::t_state                     r_state;
    dfa_pkg::t_state                     n_state;
    dfa_pkg::t_item                      r_item;
    logic [1:0]                          r_k;
    logic signed [dfa_pkg::WIDE_W-1:0]   r_dacc;
    logic signed [dfa_pkg::VAL_W-1:0]    r_dot;
    logic [dfa_pkg::PREF_W-1:0]          r_coef;
    logic signed [dfa_pkg::VAL_W-1:0]    r_inner;
    logic signed [dfa_pkg::PROD_W-1:0]   r_prod;
    logic signed [dfa_pkg::ACC_W-1:0]    r_sum [3];
    logic                                r_clip;
    logic                                r_out_valid;
    logic [dfa_pkg::OUT_DATA_W-1:0]      r_out_data;
    logic                                r_out_sat;

    logic                                w_pop;
    logic                                w_mul_en;
    logic                                w_load;
    logic                                w_div_busy;
    logic [dfa_pkg::DVD_W-1:0]           w_quot;
    logic signed [dfa_pkg::VAL_W-1:0]    w_mul_a;
    logic signed [dfa_pkg::VAL_W-1:0]    w_mul_b;
    logic signed [dfa_pkg::VAL_W-1:0]    w_m_k;
    logic signed [dfa_pkg::VAL_W-1:0]    w_d_k;
    logic                                w_ratio_ovf;
    logic [dfa_pkg::DIST_W-1:0]          w_ratio;
    logic signed [dfa_pkg::SH_W-1:0]     w_prod_sh;
    logic signed [dfa_pkg::WIDE_W-1:0]   w_prod_wide;
    logic [dfa_pkg::PROD_W-1:0]          w_cprod;
    logic signed [dfa_pkg::WIDE_W-1:0]   w_inner_wide;
    dfa_pkg::t_sat                       w_dot_sat;
    dfa_pkg::t_sat                       w_inner_sat;
    dfa_pkg::t_sat                       w_term_sat;
    dfa_pkg::t_sat                       w_fx;
    dfa_pkg::t_sat                       w_fy;
    dfa_pkg::t_sat                       w_fz;
    logic signed [dfa_pkg::ACC_W:0]      w_sum_next;
    logic signed [dfa_pkg::ACC_W-1:0]    w_sum_clip;
    logic                                w_sum_ovf;
    logic                                w_last_k;
    logic                                w_can_load;

    dfa_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_pop),
        .i_dividend ({i_head.item.source_volume, dfa_pkg::FRAC_BITS'(0)}),
        .i_divisor  (i_head.item.dist_cube),
        .o_busy     (w_div_busy),
        .o_quot     (w_quot)
    );

    always_comb begin
        case (r_k)
            2'd0:    begin w_m_k = r_item.moment_x; w_d_k = r_item.dir_x; end
            2'd1:    begin w_m_k = r_item.moment_y; w_d_k = r_item.dir_y; end
            default: begin w_m_k = r_item.moment_z; w_d_k = r_item.dir_z; end
        endcase
    end

    assign w_last_k    = (r_k == 2'd2);
    assign w_can_load  = !r_out_valid || i_out_ready;
    assign w_ratio_ovf = |w_quot[dfa_pkg::DVD_W-1:dfa_pkg::DIST_W];
    assign w_ratio     = w_ratio_ovf ? '1 : w_quot[dfa_pkg::DIST_W-1:0];
    assign w_prod_sh   = dfa_pkg::SH_W'(r_prod >>> dfa_pkg::FRAC_BITS);
    assign w_prod_wide = dfa_pkg::WIDE_W'(w_prod_sh);
    assign w_cprod     = dfa_pkg::PROD_W'(r_prod) >> dfa_pkg::FRAC_BITS;
    assign w_inner_wide = w_prod_wide + (w_prod_wide <<< 1) - dfa_pkg::WIDE_W'(w_m_k);
    assign w_dot_sat   = sat32(r_dacc);
    assign w_inner_sat = sat32(w_inner_wide);
    assign w_term_sat  = sat32(w_prod_wide);
    assign w_sum_next  = (dfa_pkg::ACC_W+1)'(r_sum[r_k])
                       + (dfa_pkg::ACC_W+1)'(w_term_sat.val);
    assign w_sum_ovf   = (w_sum_next > MAX48) || (w_sum_next < MIN48);
    assign w_sum_clip  = (w_sum_next > MAX48) ? dfa_pkg::ACC_W'(MAX48) :
                         (w_sum_next < MIN48) ? dfa_pkg::ACC_W'(MIN48) :
                         dfa_pkg::ACC_W'(w_sum_next);
    assign w_fx        = sat32(dfa_pkg::WIDE_W'(r_sum[0]));
    assign w_fy        = sat32(dfa_pkg::WIDE_W'(r_sum[1]));
    assign w_fz        = sat32(dfa_pkg::WIDE_W'(r_sum[2]));

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            dfa_pkg::S_IDLE:     if (i_head.valid) n_state = dfa_pkg::S_DIV;
            dfa_pkg::S_DIV:      if (!w_div_busy) n_state = dfa_pkg::S_DOT_MUL;
            dfa_pkg::S_DOT_MUL:  n_state = dfa_pkg::S_DOT_ACC;
            dfa_pkg::S_DOT_ACC:  n_state = w_last_k ? dfa_pkg::S_COEF_MUL : dfa_pkg::S_DOT_MUL;
            dfa_pkg::S_COEF_MUL: n_state = dfa_pkg::S_COEF;
            dfa_pkg::S_COEF:     n_state = dfa_pkg::S_AX_MUL1;
            dfa_pkg::S_AX_MUL1:  n_state = dfa_pkg::S_AX_INNER;
            dfa_pkg::S_AX_INNER: n_state = dfa_pkg::S_AX_MUL2;
            dfa_pkg::S_AX_MUL2:  n_state = dfa_pkg::S_AX_ACC;
            dfa_pkg::S_AX_ACC:   n_state = w_last_k ? dfa_pkg::S_DONE : dfa_pkg::S_AX_MUL1;
            dfa_pkg::S_DONE: begin
                if (!r_item.last_term || w_can_load) n_state = dfa_pkg::S_IDLE;
            end
            default:             n_state = dfa_pkg::S_IDLE;
        endcase
    end

    // Control outputs and multiplier operand select.
    always_comb begin
        w_pop    = 1'b0;
        w_mul_en = 1'b0;
        w_load   = 1'b0;
        w_mul_a  = w_m_k;
        w_mul_b  = w_d_k;
        unique case (r_state)
            dfa_pkg::S_IDLE:     w_pop = i_head.valid;
            dfa_pkg::S_DOT_MUL:  w_mul_en = 1'b1;
            dfa_pkg::S_COEF_MUL: begin
                w_mul_en = 1'b1;
                w_mul_a  = {1'b0, i_prefactor};
                w_mul_b  = {1'b0, w_ratio};
            end
            dfa_pkg::S_AX_MUL1: begin
                w_mul_en = 1'b1;
                w_mul_a  = r_dot;
                w_mul_b  = w_d_k;
            end
            dfa_pkg::S_AX_MUL2: begin
                w_mul_en = 1'b1;
                w_mul_a  = {1'b0, r_coef};
                w_mul_b  = r_inner;
            end
            dfa_pkg::S_DONE:     w_load = r_item.last_term && w_can_load;
            default: begin
            end
        endcase
    end

    assign o_pop       = w_pop;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;
    assign o_out_sat   = r_out_sat;

    always_ff @(posedge i_clk) begin
        if (w_pop) begin
            r_item <= i_head.item;
        end
        if (w_mul_en) begin
            r_prod <= w_mul_a * w_mul_b;
        end
        if (w_pop) begin
            r_dacc <= '0;
        end else if (r_state == dfa_pkg::S_DOT_ACC) begin
            r_dacc <= r_dacc + w_prod_wide;
        end
        if (r_state == dfa_pkg::S_COEF_MUL) begin
            r_dot <= w_dot_sat.val;
        end
        if (r_state == dfa_pkg::S_COEF) begin
            r_coef <= (|w_cprod[dfa_pkg::PROD_W-1:dfa_pkg::PREF_W]) ? '1 :
                      w_cprod[dfa_pkg::PREF_W-1:0];
        end
        if (r_state == dfa_pkg::S_AX_INNER) begin
            r_inner <= w_inner_sat.val;
        end
        if (w_load) begin
            r_out_data <= {w_fz.val, w_fy.val, w_fx.val};
            r_out_sat  <= r_clip | w_fx.clip | w_fy.clip | w_fz.clip;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= dfa_pkg::S_IDLE;
            r_k         <= '0;
            r_sum[0]    <= '0;
            r_sum[1]    <= '0;
            r_sum[2]    <= '0;
            r_clip      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if ((r_state == dfa_pkg::S_DOT_ACC) || (r_state == dfa_pkg::S_AX_ACC)) begin
                r_k <= w_last_k ? 2'd0 : r_k + 2'd1;
            end
            case (r_state)
                dfa_pkg::S_DIV: begin
                    if (!w_div_busy && w_ratio_ovf) r_clip <= 1'b1;
                end
                dfa_pkg::S_COEF_MUL: begin
                    if (w_dot_sat.clip) r_clip <= 1'b1;
                end
                dfa_pkg::S_COEF: begin
                    if (|w_cprod[dfa_pkg::PROD_W-1:dfa_pkg::PREF_W]) r_clip <= 1'b1;
                end
                dfa_pkg::S_AX_INNER: begin
                    if (w_inner_sat.clip) r_clip <= 1'b1;
                end
                dfa_pkg::S_AX_ACC: begin
                    r_sum[r_k] <= w_sum_clip;
                    if (w_term_sat.clip || w_sum_ovf) r_clip <= 1'b1;
                end
                dfa_pkg::S_DONE: begin
                    if (w_load) begin
                        r_sum[0] <= '0;
                        r_sum[1] <= '0;
                        r_sum[2] <= '0;
                        r_clip   <= 1'b0;
                    end
                end
                default: begin
                end
            endcase
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    `DFA_ASSERT_NEXT(a_clear_after_emit, w_load,
        (r_sum[0] == '0) && (r_sum[1] == '0) && (r_sum[2] == '0) && !r_clip)
    `DFA_ASSERT(a_axis_range, r_k != 2'd3)
    `DFA_ASSERT(a_div_idle, (r_state == dfa_pkg::S_IDLE) |-> !w_div_busy)

endmodule

@@ src/dipolar_field_accumulator_top.sv @@
// Channel     Dir  Beat contents
// s_axis      in   tdata: volume, cube, moment x/y/z, dir x/y/z; tlast: last term
// m_axis      out  tdata: field x/y/z; tuser: saturated (on last term only)
// i_cfg_*     in   prefactor write
// An item is dequeued, then goes through the bit-serial divider (47 steps) and the
// term math on the one shared 32x32 multiplier (product registered).
// A two-beat queue keeps taking input, until it is full, while an item is worked on.
// Reset is synchronous, active low; the prefactor returns to 1.0.
// A full output register stalls the back end on a last term until the beat is taken.
module dipolar_field_accumulator_top (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [dfa_pkg::PREF_W-1:0]        i_cfg_wdata,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // source_volume, dist_cube, moment_x/y/z, dir_x/y/z, zero pad from bit 0 up
    input  logic [dfa_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    input  logic                              s_axis_tlast,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // field_x, field_y, field_z from bit 0 up
    output logic [dfa_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
    // saturated
    output logic                              m_axis_tuser
);

    logic [dfa_pkg::PREF_W-1:0]  r_prefactor;
    dfa_pkg::t_queue_out         w_head;
    logic                        w_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prefactor <= dfa_pkg::PREF_RESET;
        end else if (i_cfg_we) begin
            r_prefactor <= i_cfg_wdata;
        end
    end

    dfa_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .i_pop         (w_pop),
        .o_head        (w_head)
    );

    dfa_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_prefactor (r_prefactor),
        .i_head      (w_head),
        .o_pop       (w_pop),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_out_data  (m_axis_tdata),
        .o_out_sat   (m_axis_tuser)
    );

endmodule
